// ===== src/sas_pkg.sv =====
// Shared types and constants for the sprite animation sequencer.
package sas_pkg;

   // Default sizes of the sequence store
   localparam int NUM_ANIMS_DEF = 16;
   localparam int SEQ_DEPTH_DEF = 32;

   // Item field widths
   localparam int CMD_W       = 2;
   localparam int ANIM_SEL_W  = 4;
   localparam int ENTRY_POS_W = 5;
   localparam int FRAME_W     = 6;

   // Control register widths
   localparam int MODE_W     = 2;
   localparam int INTERVAL_W = 16;
   localparam int COUNT_W    = 7;

   // APB-style register port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // Result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_LVL_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 2'd0,
      CMD_LOAD   = 2'd1,
      CMD_SELECT = 2'd2
   } cmd_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_NONE   = 2'd0,
      MODE_SINGLE = 2'd1,
      MODE_CYCLE  = 2'd2,
      MODE_SEQ    = 2'd3
   } mode_type;

   // Register index, taken from paddr word bits
   typedef enum logic [1:0] {
      REG_ANIM_MODE      = 2'd0,
      REG_ONE_SHOT       = 2'd1,
      REG_FRAME_INTERVAL = 2'd2,
      REG_FRAME_COUNT    = 2'd3
   } reg_idx_type;

   // What the second stage does to the current frame
   typedef enum logic [1:0] {
      ACT_HOLD  = 2'd0,
      ACT_ZERO  = 2'd1,
      ACT_CYCLE = 2'd2,
      ACT_SEQ   = 2'd3
   } act_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic               anim_done;
   } rsp_item_type;

endpackage

// ===== src/sas_if.sv =====
// Valid/ready channel interfaces for command items and result items.
interface sas_req_if;
   import sas_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CMD_W-1:0]       command;
   logic [ANIM_SEL_W-1:0]  anim_select;
   logic [ENTRY_POS_W-1:0] entry_pos;
   logic [FRAME_W-1:0]     entry_frame;
   logic                   entry_last;

   modport source (
      output valid, command, anim_select, entry_pos, entry_frame, entry_last,
      input  ready
   );
   modport sink (
      input  valid, command, anim_select, entry_pos, entry_frame, entry_last,
      output ready
   );
endinterface

interface sas_rsp_if;
   import sas_pkg::*;

   logic               valid;
   logic               ready;
   logic [FRAME_W-1:0] frame;
   logic               anim_done;

   modport source (
      output valid, frame, anim_done,
      input  ready
   );
   modport sink (
      input  valid, frame, anim_done,
      output ready
   );
endinterface

// ===== src/sas_rsp_fifo.sv =====
// Small result queue that decouples the pipeline from the result channel.
module sas_rsp_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  sas_pkg::rsp_item_type          push_item,
   input  logic                           pop,
   output logic                           head_valid,
   output sas_pkg::rsp_item_type          head_item,
   output logic [sas_pkg::RSP_LVL_W-1:0]  level
);
   import sas_pkg::*;

   rsp_item_type           slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_LVL_W-1:0]   level_ff,  level_in;

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff + RSP_LVL_W'(push) - RSP_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Payload slots, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_valid = (level_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign level      = level_ff;

endmodule

// ===== src/sprite_animation_sequencer.sv =====
// Sprite animation sequencer: command decode, sequence memories and frame update.
// Each accepted item passes the stage-two register and the result queue before its result is offered.
// Throughput: one item per cycle; the 4-entry result queue absorbs output stalls,
// and req ready drops only when the queue plus the item in flight would overflow it.
// The sequence table and length store are synchronous memories with registered reads; the
// length of the current animation is read every cycle with a write bypass.
// Reset (synchronous) clears the control state (frame count resets to one) and the length valid bits at once.
module sprite_animation_sequencer #(
   parameter int NUM_ANIMS = sas_pkg::NUM_ANIMS_DEF,
   parameter int SEQ_DEPTH = sas_pkg::SEQ_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   sas_req_if.sink                     req_if,
   sas_rsp_if.source                   rsp_if,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [sas_pkg::CSR_AW-1:0]  paddr,
   input  logic [sas_pkg::CSR_DW-1:0]  pwdata,
   output logic [sas_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   import sas_pkg::*;

   localparam int ANIM_W    = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
   localparam int POS_W     = $clog2(SEQ_DEPTH);
   localparam int LEN_W     = $clog2(SEQ_DEPTH + 1);
   localparam int TBL_DEPTH = NUM_ANIMS * SEQ_DEPTH;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);

   // Control registers
   mode_type               mode_ff;
   logic                   one_shot_ff;
   logic [INTERVAL_W-1:0]  interval_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic                   csr_wr;
   reg_idx_type            csr_idx;

   // Sequencer state
   logic [INTERVAL_W-1:0]  tick_ff,   tick_in;
   logic [POS_W-1:0]       pos_ff,    pos_in;
   logic [ANIM_W-1:0]      anim_ff,   anim_in;
   logic                   done_ff,   done_in;
   logic [FRAME_W-1:0]     frame_ff,  frame_in;

   // Memories
   logic [FRAME_W-1:0]     seq_tbl_ff [TBL_DEPTH];
   logic [FRAME_W-1:0]     tbl_rd_ff;
   logic [LEN_W-1:0]       seq_len_ff [NUM_ANIMS];
   logic [NUM_ANIMS-1:0]   len_valid_ff;
   logic [LEN_W-1:0]       len_rd_ff;
   logic                   len_vld_ff;
   logic                   len_byp_ff;
   logic [LEN_W-1:0]       len_byp_data_ff;
   logic [LEN_W-1:0]       len_cur;

   // Stage two
   logic                   d1_valid_ff;
   act_type                d1_act_ff;
   logic                   d1_done_ff;
   act_type                act;

   // Stage one decode
   logic                   req_acc;
   logic                   load_ok;
   logic                   anim_ok;
   logic [ANIM_W-1:0]      sel_idx;
   logic                   tbl_we;
   logic                   tbl_re;
   logic                   len_we;
   logic [TBL_AW-1:0]      tbl_wr_addr;
   logic [TBL_AW-1:0]      tbl_rd_addr;
   logic [LEN_W-1:0]       len_wdata;
   logic [INTERVAL_W:0]    tick_sum;
   logic                   pace_adv;
   logic [INTERVAL_W-1:0]  pace_tick;
   logic [POS_W:0]         pos_inc;
   logic                   seq_end;
   logic [POS_W-1:0]       seq_pos_next;

   // Cyclic frame step
   logic [FRAME_W:0]       cyc_sum;
   logic [FRAME_W-1:0]     cyc_next;

   // Result queue
   rsp_item_type           push_item;
   rsp_item_type           head_item;
   logic                   head_valid;
   logic [RSP_LVL_W-1:0]   rsp_level;
   logic [RSP_LVL_W-1:0]   in_flight;
   logic                   rsp_pop;

   // ---------------- register port ----------------
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = reg_idx_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_NONE;
         one_shot_ff <= 1'b0;
         interval_ff <= '0;
         count_ff    <= COUNT_W'(1);
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ANIM_MODE:      mode_ff     <= mode_type'(pwdata[MODE_W-1:0]);
            REG_ONE_SHOT:       one_shot_ff <= pwdata[0];
            REG_FRAME_INTERVAL: interval_ff <= pwdata[INTERVAL_W-1:0];
            REG_FRAME_COUNT:    count_ff    <= pwdata[COUNT_W-1:0];
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_idx)
         REG_ANIM_MODE:      prdata[MODE_W-1:0]     = mode_ff;
         REG_ONE_SHOT:       prdata[0]              = one_shot_ff;
         REG_FRAME_INTERVAL: prdata[INTERVAL_W-1:0] = interval_ff;
         REG_FRAME_COUNT:    prdata[COUNT_W-1:0]    = count_ff;
      endcase
   end

   // ---------------- stage one: decode and state update ----------------
   assign in_flight    = rsp_level + RSP_LVL_W'(d1_valid_ff);
   assign req_if.ready = !reset && (in_flight < RSP_LVL_W'(RSP_DEPTH));
   assign req_acc      = req_if.valid & req_if.ready;

   assign anim_ok   = int'(req_if.anim_select) < NUM_ANIMS;
   assign load_ok   = anim_ok && (int'(req_if.entry_pos) < SEQ_DEPTH);
   assign sel_idx   = ANIM_W'(req_if.anim_select);
   assign len_wdata = LEN_W'({1'b0, req_if.entry_pos} + (ENTRY_POS_W + 1)'(1));

   // Length of the current animation; unwritten entries read as one
   assign len_cur = len_byp_ff ? len_byp_data_ff :
                    len_vld_ff ? len_rd_ff : LEN_W'(1);

   // Tick pacing against the interval
   assign tick_sum  = {1'b0, tick_ff} + (INTERVAL_W + 1)'(1);
   assign pace_adv  = tick_sum >= {1'b0, interval_ff};
   assign pace_tick = pace_adv ? '0 : tick_sum[INTERVAL_W-1:0];

   // Next sequence position: loop or hold at the end
   assign pos_inc = {1'b0, pos_ff} + (POS_W + 1)'(1);
   assign seq_end = pos_inc >= (POS_W + 1)'(len_cur);
   always_comb begin
      if (!seq_end) begin
         seq_pos_next = pos_inc[POS_W-1:0];
      end else if (one_shot_ff) begin
         seq_pos_next = POS_W'(len_cur - LEN_W'(1));
      end else begin
         seq_pos_next = '0;
      end
   end

   assign tbl_wr_addr = TBL_AW'(sel_idx) * TBL_AW'(SEQ_DEPTH) + TBL_AW'(req_if.entry_pos);
   assign tbl_rd_addr = TBL_AW'(anim_ff) * TBL_AW'(SEQ_DEPTH) + TBL_AW'(seq_pos_next);

   always_comb begin
      tick_in = tick_ff;
      pos_in  = pos_ff;
      anim_in = anim_ff;
      done_in = done_ff;
      act     = ACT_HOLD;
      tbl_we  = 1'b0;
      tbl_re  = 1'b0;
      len_we  = 1'b0;
      if (req_acc) begin
         unique case (req_if.command)
            CMD_TICK: begin
               unique case (mode_ff)
                  MODE_NONE: begin
                  end
                  MODE_SINGLE: begin
                     act = ACT_ZERO;
                  end
                  MODE_CYCLE: begin
                     tick_in = pace_tick;
                     if (pace_adv) begin
                        act = ACT_CYCLE;
                     end
                  end
                  MODE_SEQ: begin
                     tick_in = pace_tick;
                     if (pace_adv) begin
                        act     = ACT_SEQ;
                        tbl_re  = 1'b1;
                        pos_in  = seq_pos_next;
                        done_in = done_ff | (seq_end & one_shot_ff);
                     end
                  end
               endcase
            end
            CMD_LOAD: begin
               if (load_ok) begin
                  tbl_we = 1'b1;
                  len_we = req_if.entry_last;
               end
            end
            CMD_SELECT: begin
               if (anim_ok) begin
                  anim_in = sel_idx;
                  pos_in  = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         pos_ff      <= '0;
         anim_ff     <= '0;
         done_ff     <= 1'b0;
         d1_valid_ff <= 1'b0;
         d1_act_ff   <= ACT_HOLD;
         d1_done_ff  <= 1'b0;
      end else begin
         tick_ff     <= tick_in;
         pos_ff      <= pos_in;
         anim_ff     <= anim_in;
         done_ff     <= done_in;
         d1_valid_ff <= req_acc;
         d1_act_ff   <= act;
         d1_done_ff  <= done_in;
      end
   end

   // Sequence table: written by loads, read on sequence advances
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         seq_tbl_ff[tbl_wr_addr] <= req_if.entry_frame;
      end
      if (tbl_re) begin
         tbl_rd_ff <= seq_tbl_ff[tbl_rd_addr];
      end
   end

   // Length store: read every cycle at the animation that is current next cycle
   always_ff @(posedge clock) begin
      if (len_we) begin
         seq_len_ff[sel_idx] <= len_wdata;
      end
      len_rd_ff       <= seq_len_ff[anim_in];
      len_byp_data_ff <= len_wdata;
   end

   // Length valid bits and same-entry bypass
   always_ff @(posedge clock) begin
      if (reset) begin
         len_valid_ff <= '0;
         len_vld_ff   <= 1'b0;
         len_byp_ff   <= 1'b0;
      end else begin
         if (len_we) begin
            len_valid_ff[sel_idx] <= 1'b1;
         end
         len_vld_ff <= len_valid_ff[anim_in];
         len_byp_ff <= len_we && (sel_idx == anim_in);
      end
   end

   // ---------------- stage two: frame update ----------------
   assign cyc_sum  = {1'b0, frame_ff} + (FRAME_W + 1)'(1);
   assign cyc_next = ((cyc_sum >= count_ff) || cyc_sum[FRAME_W]) ? '0 : cyc_sum[FRAME_W-1:0];

   always_comb begin
      unique case (d1_act_ff)
         ACT_HOLD:  frame_in = frame_ff;
         ACT_ZERO:  frame_in = '0;
         ACT_CYCLE: frame_in = cyc_next;
         ACT_SEQ:   frame_in = tbl_rd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else if (d1_valid_ff) begin
         frame_ff <= frame_in;
      end
   end

   assign push_item.frame     = frame_in;
   assign push_item.anim_done = d1_done_ff;

   // ---------------- result queue ----------------
   assign rsp_pop = rsp_if.valid & rsp_if.ready;

   sas_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (d1_valid_ff),
      .push_item  (push_item),
      .pop        (rsp_pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .level      (rsp_level)
   );

   assign rsp_if.valid     = head_valid;
   assign rsp_if.frame     = head_item.frame;
   assign rsp_if.anim_done = head_item.anim_done;

endmodule

// ===== src/sas_checker.sv =====
// Port-level checks for the sprite animation sequencer, bound to the top level.
module sas_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [sas_pkg::FRAME_W-1:0]  rsp_frame,
   input  logic                         rsp_anim_done
);
   import sas_pkg::*;

   logic [RSP_LVL_W:0] outstanding_ff;
   logic               seen_done_ff;

   // Items accepted but not yet delivered; sticky copy of the done flag
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         seen_done_ff   <= 1'b0;
      end else begin
         outstanding_ff <= outstanding_ff + (RSP_LVL_W + 1)'(req_valid & req_ready)
                                          - (RSP_LVL_W + 1)'(rsp_valid & rsp_ready);
         if (rsp_valid && rsp_ready && rsp_anim_done) begin
            seen_done_ff <= 1'b1;
         end
      end
   end

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_frame) && $stable(rsp_anim_done))
      else $error("result payload changed while stalled");

   // No result without an accepted item behind it
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff == '0 |-> !rsp_valid)
      else $error("result offered with no item outstanding");

   // Done stays set until reset
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      seen_done_ff && rsp_valid |-> rsp_anim_done)
      else $error("done flag dropped after being reported");

endmodule

bind sprite_animation_sequencer sas_checker u_sas_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_frame     (rsp_if.frame),
   .rsp_anim_done (rsp_if.anim_done)
);
